/* hdl/keypad_servo_angle_entry_unit_defines.svh */
// Assertion macros shared by the keypad angle entry logic.
`ifndef KEYPAD_SERVO_ANGLE_ENTRY_UNIT_DEFINES_SVH
`define KEYPAD_SERVO_ANGLE_ENTRY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KSAE_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KSAE_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* hdl/ksae_pkg.sv */
package ksae_pkg;

   localparam int MAX_DIGITS = 3;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int MAG_W      = $clog2(10 ** MAX_DIGITS);

   localparam logic [7:0] KEY_STAR = 8'h2A;
   localparam logic [7:0] KEY_HASH = 8'h23;
   localparam logic [7:0] KEY_ZERO = 8'h30;
   localparam logic [7:0] KEY_NINE = 8'h39;

   localparam logic [7:0] WIDTH_CENTER = 8'd150;
   localparam logic [7:0] WIDTH_MIN    = 8'd100;
   localparam logic [7:0] WIDTH_MAX    = 8'd200;
   localparam int         ANGLE_LIMIT  = 45;

   // floor(n / 9) == (n * 456) >> 12 for n up to 511
   localparam int RECIP_NINE  = 456;
   localparam int RECIP_SHIFT = 12;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_SECOND = 2'd2
   } mode_type;

endpackage

/* hdl/keypad_servo_angle_entry_unit.sv */
// Keypad servo angle entry: one ASCII key per item on the req_ channel, one
// result per item on the rsp_ channel carrying both servo widths (10 us
// ticks), the entry mode, the digits held and a reject flag for an enter key
// whose angle magnitude exceeds 45. Each item is handled by combinational logic
// ahead of the state registers, which also serve as the result register; a new
// item is taken every cycle as long as the pending result is taken in the same
// cycle (req_ready follows rsp_ready whenever a result is held), and rsp_valid is
// set in the cycle after an item is accepted.
`include "keypad_servo_angle_entry_unit_defines.svh"

module keypad_servo_angle_entry_unit
   import ksae_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_servo_one_width,
   output logic [7:0] rsp_servo_two_width,
   output logic [1:0] rsp_entry_mode,
   output logic [1:0] rsp_digits_held,
   output logic       rsp_angle_rejected
);

   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [3:0]       digits_ff [MAX_DIGITS];
   logic [3:0]       digits_in [MAX_DIGITS];
   logic [7:0]       servo_one_ff, servo_one_in;
   logic [7:0]       servo_two_ff, servo_two_in;
   logic             rejected_ff, rejected_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             negative;
   logic [MAG_W-1:0] mag;
   logic             mag_ok;
   logic [9:0]       tenfold;
   logic [18:0]      scaled;
   logic [6:0]       offset;
   logic             add_offset;
   logic [8:0]       sum;
   logic [7:0]       width;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // parse held digits; a leading zero with more digits marks a negative angle
   always_comb begin
      negative = (digits_ff[0] == 4'd0) && (count_ff > CNT_W'(1));
      mag      = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if ((CNT_W'(i) < count_ff) && !(negative && (i == 0))) begin
            mag = MAG_W'(mag * MAG_W'(10)) + MAG_W'(digits_ff[i]);
         end
      end
   end

   assign mag_ok     = (mag <= MAG_W'(ANGLE_LIMIT));
   assign tenfold    = 10'(mag[5:0]) * 10'd10;
   assign scaled     = 19'(tenfold) * 19'(RECIP_NINE);
   assign offset     = 7'(scaled >> RECIP_SHIFT);
   assign add_offset = negative ^ (mode_ff == MODE_SECOND);
   assign sum        = add_offset ? (9'(WIDTH_CENTER) + 9'(offset))
                                  : (9'(WIDTH_CENTER) - 9'(offset));

   always_comb begin
      if (sum < 9'(WIDTH_MIN)) begin
         width = WIDTH_MIN;
      end else if (sum > 9'(WIDTH_MAX)) begin
         width = WIDTH_MAX;
      end else begin
         width = sum[7:0];
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      servo_one_in = servo_one_ff;
      servo_two_in = servo_two_ff;
      rejected_in  = 1'b0;
      if (req_key_char == KEY_STAR) begin
         mode_in      = MODE_FIRST;
         count_in     = '0;
         servo_one_in = WIDTH_CENTER;
         servo_two_in = WIDTH_CENTER;
      end else if (req_key_char == KEY_HASH) begin
         if (count_ff != '0) begin
            if (mag_ok) begin
               case (mode_ff)
                  MODE_FIRST: begin
                     servo_one_in = width;
                     mode_in      = MODE_SECOND;
                  end
                  MODE_SECOND: begin
                     servo_two_in = width;
                     mode_in      = MODE_IDLE;
                  end
                  default: begin
                  end
               endcase
            end else begin
               rejected_in = 1'b1;
            end
            count_in = '0;
         end
      end else if (req_key_char inside {[KEY_ZERO:KEY_NINE]}) begin
         if ((count_ff < CNT_W'(MAX_DIGITS)) && (mode_ff != MODE_IDLE)) begin
            digits_in[count_ff[IDX_W-1:0]] = req_key_char[3:0];
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         count_ff     <= '0;
         servo_one_ff <= WIDTH_CENTER;
         servo_two_ff <= WIDTH_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff      <= mode_in;
            count_ff     <= count_in;
            servo_one_ff <= servo_one_in;
            servo_two_ff <= servo_two_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         digits_ff   <= digits_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_servo_one_width = servo_one_ff;
   assign rsp_servo_two_width = servo_two_ff;
   assign rsp_entry_mode      = mode_ff;
   assign rsp_digits_held     = count_ff[1:0];
   assign rsp_angle_rejected  = rejected_ff;

   `KSAE_ASSERT_NOW(a_idle_no_digits, mode_ff == MODE_IDLE, count_ff == '0,
      "digits held while idle")
   `KSAE_ASSERT_NOW(a_reject_clears, rsp_valid_ff && rejected_ff, count_ff == '0,
      "rejected angle left digits held")
   `KSAE_ASSERT_NOW(a_width_range, 1'b1,
      (servo_one_ff >= WIDTH_MIN) && (servo_one_ff <= WIDTH_MAX) &&
      (servo_two_ff >= WIDTH_MIN) && (servo_two_ff <= WIDTH_MAX),
      "servo width out of range")
   `KSAE_ASSERT_NEXT(a_star_centers, accept && (req_key_char == KEY_STAR),
      (mode_ff == MODE_FIRST) && (servo_one_ff == WIDTH_CENTER) &&
      (servo_two_ff == WIDTH_CENTER) && (count_ff == '0),
      "reset key did not center servos")
   `KSAE_ASSERT_NOW(a_no_overrun, rsp_valid_ff && !rsp_ready, !req_ready,
      "item accepted over a pending result")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb
   import ksae_pkg::*;
();

   localparam int RUN_ITEMS  = 1500;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 10;

   class servo_readout_board;
      typedef struct packed {
         logic [7:0] width_one;
         logic [7:0] width_two;
         logic [1:0] mode;
         logic [1:0] held;
         logic       rejected;
      } readout_type;

      readout_type expected_q[$];
      mode_type    mode;
      logic [3:0]  digit_buf[MAX_DIGITS];
      int          held;
      logic [7:0]  width_one;
      logic [7:0]  width_two;
      int          errors;
      int          checked;
      int          stored;
      int          rejects;

      function new();
         mode      = MODE_IDLE;
         held      = 0;
         width_one = WIDTH_CENTER;
         width_two = WIDTH_CENTER;
         foreach (digit_buf[i]) digit_buf[i] = '0;
         errors  = 0;
         checked = 0;
         stored  = 0;
         rejects = 0;
      endfunction

      function readout_type step_key(logic [7:0] key);
         readout_type r;
         int          mag;
         int          first;
         int          off;
         int          width;
         bit          neg;
         bit          rej;
         rej = 1'b0;
         if (key == KEY_STAR) begin
            mode      = MODE_FIRST;
            held      = 0;
            width_one = WIDTH_CENTER;
            width_two = WIDTH_CENTER;
         end else if (key == KEY_HASH) begin
            if (held > 0) begin
               neg   = (digit_buf[0] == 4'd0) && (held > 1);
               first = neg ? 1 : 0;
               mag   = 0;
               for (int i = first; i < held; i++) mag = mag * 10 + int'(digit_buf[i]);
               if (mag <= ANGLE_LIMIT) begin
                  off = (mag * 100) / 90;
                  if (!neg) off = -off;
                  if (mode == MODE_SECOND) off = -off;
                  width = int'(WIDTH_CENTER) + off;
                  if (width < int'(WIDTH_MIN)) width = int'(WIDTH_MIN);
                  if (width > int'(WIDTH_MAX)) width = int'(WIDTH_MAX);
                  if (mode == MODE_FIRST) begin
                     width_one = 8'(width);
                     mode      = MODE_SECOND;
                     stored++;
                  end else if (mode == MODE_SECOND) begin
                     width_two = 8'(width);
                     mode      = MODE_IDLE;
                     stored++;
                  end
               end else begin
                  rej = 1'b1;
                  rejects++;
               end
               held = 0;
            end
         end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
            if (held < MAX_DIGITS && mode != MODE_IDLE) begin
               digit_buf[held] = 4'(key - KEY_ZERO);
               held++;
            end
         end
         r.width_one = width_one;
         r.width_two = width_two;
         r.mode      = mode;
         r.held      = 2'(held);
         r.rejected  = rej;
         return r;
      endfunction

      function void note_key(logic [7:0] key);
         expected_q.push_back(step_key(key));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_field(string name, int got, int want);
         if (got != want)
            report($sformatf("%s got %0d, want %0d", name, got, want));
      endtask

      task check_result(logic [7:0] one, logic [7:0] two, logic [1:0] md,
                        logic [1:0] hd, logic rj);
         readout_type e;
         if (expected_q.size() == 0) begin
            report("result with no item outstanding");
         end else begin
            e = expected_q.pop_front();
            checked++;
            check_field("servo_one_width", int'(one), int'(e.width_one));
            check_field("servo_two_width", int'(two), int'(e.width_two));
            check_field("entry_mode", int'(md), int'(e.mode));
            check_field("digits_held", int'(hd), int'(e.held));
            check_field("angle_rejected", int'(rj), int'(e.rejected));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_key_char = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_servo_one_width;
   logic [7:0] rsp_servo_two_width;
   logic [1:0] rsp_entry_mode;
   logic [1:0] rsp_digits_held;
   logic       rsp_angle_rejected;

   servo_readout_board readouts = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int keys_sent = 0;
   int cycles = 0;

   keypad_servo_angle_entry_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_key_char        (req_key_char),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_servo_one_width (rsp_servo_one_width),
      .rsp_servo_two_width (rsp_servo_two_width),
      .rsp_entry_mode      (rsp_entry_mode),
      .rsp_digits_held     (rsp_digits_held),
      .rsp_angle_rejected  (rsp_angle_rejected)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("[keypad_servo_angle_entry_unit] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         readouts.check_result(rsp_servo_one_width, rsp_servo_two_width, rsp_entry_mode,
                               rsp_digits_held, rsp_angle_rejected);
   end

   function automatic logic [7:0] digit_key(int d);
      return KEY_ZERO + 8'(d);
   endfunction

   task automatic send_key(logic [7:0] key);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid    <= 1'b1;
      req_key_char <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      readouts.note_key(key);
      keys_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (readouts.pending() != 0);
   endtask

   task automatic type_angle();
      logic [7:0] keys[$];
      int         mag;
      int         n;
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) keys.push_back(digit_key($urandom_range(9)));
      end else begin
         mag = ($urandom_range(3) == 0) ? $urandom_range(46, 99) : $urandom_range(0, 45);
         if ($urandom_range(1) == 1) keys.push_back(digit_key(0));
         if (mag >= 10) keys.push_back(digit_key(mag / 10));
         keys.push_back(digit_key(mag % 10));
      end
      foreach (keys[i]) begin
         if ($urandom_range(9) == 0) send_key(8'($urandom_range(255)));
         send_key(keys[i]);
      end
      send_key(KEY_HASH);
   endtask

   task automatic run_session();
      if ($urandom_range(19) != 0) send_key(KEY_STAR);
      type_angle();
      if ($urandom_range(9) == 0) send_key(KEY_HASH);
      type_angle();
      if ($urandom_range(4) == 0) type_angle();
      if ($urandom_range(9) == 0) send_key(8'($urandom_range(255)));
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{8'h00, 8'hFF, digit_key(5), KEY_HASH, KEY_STAR, KEY_HASH,
                   digit_key(4), digit_key(5), KEY_HASH,
                   digit_key(0), digit_key(4), digit_key(5), KEY_HASH,
                   KEY_STAR, digit_key(1), digit_key(2), digit_key(3), digit_key(9),
                   KEY_HASH, digit_key(0), KEY_HASH,
                   digit_key(0), digit_key(9), KEY_HASH, KEY_STAR};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_key(directed[i]);
      wait_drained();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         while (keys_sent < directed.size() + (phase + 1) * (RUN_ITEMS / 4)) run_session();
         wait_drained();
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (readouts.pending() != 0)
         readouts.report($sformatf("%0d results never arrived", readouts.pending()));
      $display("covered %0d keys over four handshake phases: %0d results checked,",
               keys_sent, readouts.checked);
      $display("%0d angles stored to a servo and %0d angles rejected as out of range",
               readouts.stored, readouts.rejects);
      if (readouts.errors == 0) begin
         $display("[keypad_servo_angle_entry_unit] OK");
      end else begin
         $display("[keypad_servo_angle_entry_unit] ERROR");
      end
      $finish;
   end
endmodule
